@@ hdl/sha1_pkg.sv @@
package sha1_pkg;
   localparam int INPUT_BITS = 32;
   localparam int CNT_W = 6;

   typedef struct packed {
      logic [31:0]      bits;
      logic [CNT_W-1:0] count;
      logic             eom;
   } req_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PACK, ST_ROUND, ST_PAD, ST_LEN, ST_EMIT
   } state_type;

   localparam logic [159:0] INIT_HASH =
      160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) k = 32'h5a827999;
      else if (r < 7'd40) k = 32'h6ed9eba1;
      else if (r < 7'd60) k = 32'h8f1bbcdc;
      else k = 32'hca62c1d6;
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r,
                                           input logic [31:0] b, c, d);
      logic [31:0] f;
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
   endfunction
endpackage

@@ hdl/sha1_req_fifo.sv @@
module sha1_req_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  sha1_pkg::req_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output sha1_pkg::req_type rd_data,
   output logic              empty
);
   import sha1_pkg::*;

   req_type    mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full    = (cnt_ff == 3'd4);
   assign empty   = (cnt_ff == 3'd0);
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en && !full) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en && !full) wp_ff <= wp_ff + 2'd1;
         if (rd_en && !empty) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr_en && !full} - {2'd0, rd_en && !empty};
      end
   end
endmodule

@@ hdl/sha1_core.sv @@
module sha1_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sha1_pkg::req_type in_data,
   output logic              in_take,
   output logic              out_valid,
   output logic [31:0]       out_word,
   output logic [2:0]        out_index,
   input  logic              out_ready
);
   import sha1_pkg::*;

   state_type      st_ff, st_in;
   logic [511:0]   buf_ff, buf_in;
   logic [159:0]   h_ff, h_in;
   logic [159:0]   v_ff, v_in;
   logic [511:0]   w_ff, w_in;
   logic [63:0]    len_ff, len_in;
   logic [6:0]     rnd_ff, rnd_in;
   logic [5:0]     bit_ff, bit_in;   // bit inside current request
   logic [5:0]     n_ff, n_in;
   logic [31:0]    bits_ff, bits_in;
   logic           eom_ff, eom_in;
   logic           padb_ff, padb_in; // compress returns to pad-length step
   logic [2:0]     idx_ff, idx_in;

   logic [8:0]   pos;
   logic [31:0]  a, b, c, d, e, wn, tmp;
   logic [5:0]   nsat;

   assign pos = len_ff[8:0];
   assign {a, b, c, d, e} = v_ff;
   assign nsat = (in_data.count > 6'(INPUT_BITS)) ? 6'(INPUT_BITS) : in_data.count;

   always_comb begin
      st_in = st_ff; buf_in = buf_ff; h_in = h_ff; v_in = v_ff; w_in = w_ff;
      len_in = len_ff; rnd_in = rnd_ff; bit_in = bit_ff; n_in = n_ff;
      bits_in = bits_ff; eom_in = eom_ff; padb_in = padb_ff; idx_in = idx_ff;
      in_take = 1'b0; out_valid = 1'b0;
      out_word = h_ff[159 - 32*idx_ff -: 32]; out_index = idx_ff;
      wn = w_ff[511:480];
      if (rnd_ff >= 7'd16) begin
         wn = w_ff[447:416] ^ w_ff[255:224] ^ w_ff[95:64] ^ w_ff[511:480];
         wn = {wn[30:0], wn[31]};
      end
      tmp = {a[26:0], a[31:27]} + round_f(rnd_ff, b, c, d) + round_k(rnd_ff) + e + wn;
      unique case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               in_take = 1'b1; bits_in = in_data.bits; n_in = nsat;
               eom_in = in_data.eom; bit_in = '0; st_in = ST_PACK;
            end
         end
         ST_PACK: begin
            // one bit per cycle; a full block starts the rounds
            if (bit_ff < n_ff) begin
               buf_in[511 - pos] = bits_ff[31 - bit_ff[4:0]];
               len_in = len_ff + 64'd1;
               bit_in = bit_ff + 6'd1;
               if (pos == 9'd511) begin
                  padb_in = 1'b0; st_in = ST_ROUND; rnd_in = '0;
                  v_in = h_ff; w_in = buf_in;
               end
            end else if (eom_ff) st_in = ST_PAD;
            else st_in = ST_IDLE;
         end
         ST_PAD: begin
            buf_in[511 - pos] = 1'b1;
            if (pos > 9'd447) begin
               padb_in = 1'b1; st_in = ST_ROUND; rnd_in = '0;
               v_in = h_ff; w_in = buf_in;
            end else st_in = ST_LEN;
         end
         ST_LEN: begin
            buf_in[63:0] = len_ff; padb_in = 1'b0; eom_in = 1'b0;
            st_in = ST_ROUND; rnd_in = '0; v_in = h_ff; w_in = buf_in;
            idx_in = 3'd7; // marks final block
         end
         ST_ROUND: begin
            v_in = {tmp, a, {b[1:0], b[31:2]}, c, d};
            w_in = {w_ff[479:0], wn};
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               h_in = {h_ff[159:128] + tmp, h_ff[127:96] + a,
                       h_ff[95:64] + {b[1:0], b[31:2]}, h_ff[63:32] + c,
                       h_ff[31:0] + d};
               buf_in = '0;
               if (padb_ff) st_in = ST_LEN;
               else if (idx_ff == 3'd7) begin st_in = ST_EMIT; idx_in = '0; end
               else st_in = ST_PACK;
            end
         end
         ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  st_in = ST_IDLE; h_in = INIT_HASH; len_in = '0; idx_in = '0;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; h_ff <= INIT_HASH; len_ff <= '0; buf_ff <= '0;
         idx_ff <= '0; padb_ff <= 1'b0;
      end else begin
         st_ff <= st_in; h_ff <= h_in; len_ff <= len_in; buf_ff <= buf_in;
         idx_ff <= idx_in; padb_ff <= padb_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in; w_ff <= w_in; rnd_ff <= rnd_in; bit_ff <= bit_in;
      n_ff <= n_in; bits_ff <= bits_in; eom_ff <= eom_in;
   end
endmodule

@@ hdl/sha1_bit_stream_hasher_unit.sv @@
// SHA-1 over a bit-granular stream. Each request carries up to 32 message
// bits, MSB first, a valid count (saturated at 32) and an end-of-message
// flag. A four-entry request queue decouples the front from the hash core.
// The core packs one bit per cycle, runs 80 rounds per full block on one
// round unit, and on end of message pads, runs one or two final blocks and
// returns five digest words, H0 first, through a two-entry result queue.
// Beyond its bits, a request costs the rounds of each block it fills. End of
// message adds a pad step, an extra block of rounds when the pad bit lands
// past bit 447, a length step, the rounds of the final block and the
// hand-out of the digest words.
module sha1_bit_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_message_bits,
   input  logic [5:0]  req_valid_bits,
   input  logic        req_end_of_message,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1_pkg::*;

   req_type     in_req;
   req_type     q_data;
   logic        q_empty, take;
   logic        c_valid, c_ready;
   logic [31:0] c_word;
   logic [2:0]  c_idx;

   // hold results in a two-entry skid queue
   logic [34:0] rq_ff [2];
   logic        rp_ff, wp_ff;
   logic [1:0]  rc_ff;

   assign in_req = {req_message_bits, req_valid_bits, req_end_of_message};

   sha1_req_fifo u_fifo (
      .clock(clock), .reset(reset), .wr_en(push), .wr_data(in_req),
      .full(full), .rd_en(take), .rd_data(q_data), .empty(q_empty));

   sha1_core u_core (
      .clock(clock), .reset(reset), .in_valid(!q_empty), .in_data(q_data),
      .in_take(take), .out_valid(c_valid), .out_word(c_word),
      .out_index(c_idx), .out_ready(c_ready));

   assign c_ready = (rc_ff != 2'd2);
   assign empty = (rc_ff == 2'd0);
   assign {rsp_digest_word, rsp_word_index} = rq_ff[rp_ff];
   assign rsp_last_word = (rsp_word_index == 3'd4);

   always_ff @(posedge clock) begin
      if (c_valid && c_ready) rq_ff[wp_ff] <= {c_word, c_idx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff <= 1'b0; wp_ff <= 1'b0; rc_ff <= '0;
      end else begin
         if (c_valid && c_ready) wp_ff <= !wp_ff;
         if (pop && !empty) rp_ff <= !rp_ff;
         rc_ff <= rc_ff + {1'b0, c_valid && c_ready} - {1'b0, pop && !empty};
      end
   end

   a_idx: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_word_index <= 3'd4) else $error("bad word index");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rc_ff <= 2'd2) else $error("result queue overflow");
   a_take: assert property (@(posedge clock) disable iff (reset)
      take |-> !q_empty) else $error("take from empty queue");
endmodule
